FILE: src/kls_pkg.sv
// Package for the k-mer common prefix statistics block: payload types, constants and helpers.
package kls_pkg;

  localparam int LEN_W  = 7;
  localparam int K1_W   = 6;
  localparam int WORD_W = 64;
  localparam int SUM_W  = 46;
  localparam int SQ_W   = 52;
  localparam int PAIR_W = 40;
  localparam int POS_W  = 7;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic CFG_KMER_LENGTH   = 1'b0;
  localparam logic CFG_PREFIX_LENGTH = 1'b1;
  localparam int   CFG_DATA_W        = LEN_W;

  localparam logic [LEN_W-1:0] KMER_LENGTH_RST   = 7'd31;
  localparam logic [K1_W-1:0]  PREFIX_LENGTH_RST = 6'd16;

  // Masks for the halving search of the highest set bit.
  localparam logic [WORD_W-1:0] LZ_MASKS [6] = '{
    64'hFFFF_FFFF_0000_0000,
    64'hFFFF_0000_FFFF_0000,
    64'hFF00_FF00_FF00_FF00,
    64'hF0F0_F0F0_F0F0_F0F0,
    64'hCCCC_CCCC_CCCC_CCCC,
    64'hAAAA_AAAA_AAAA_AAAA
  };

  typedef struct packed {
    logic [WORD_W-1:0] first_prefix;
    logic [WORD_W-1:0] first_suffix;
    logic [WORD_W-1:0] second_prefix;
    logic [WORD_W-1:0] second_suffix;
  } kls_in_t;

  typedef struct packed {
    logic [LEN_W-1:0]  lcp_length;
    logic [SUM_W-1:0]  lcp_total;
    logic [SQ_W-1:0]   lcp_square_total;
    logic [PAIR_W-1:0] pair_count;
  } kls_out_t;

  typedef struct packed {
    logic [LEN_W-1:0] kmer_length;
    logic [K1_W-1:0]  prefix_length;
  } kls_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kls_qstat_t;

  // Number of bits up to and including the highest set bit; v is nonzero.
  function automatic logic [POS_W-1:0] top_bit_pos(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] w;
    logic [POS_W-1:0]  lz;
    w  = v;
    lz = '0;
    for (int i = 0; i < 6; i++) begin
      if ((w & LZ_MASKS[i]) != '0) begin
        w = w & LZ_MASKS[i];
      end else begin
        lz = lz + (POS_W'(32) >> i);
      end
    end
    return POS_W'(64) - lz;
  endfunction

endpackage

FILE: src/kls_front.sv
// Front end: accepts a k-mer pair and works out its common prefix length.
module kls_front (
  input  kls_pkg::kls_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  kls_pkg::kls_in_t             in_data,
  input  kls_pkg::kls_qstat_t          q_stat,
  output logic                         q_push,
  output logic [kls_pkg::LEN_W-1:0]    q_len
);

  logic [kls_pkg::WORD_W-1:0] pre_diff;
  logic [kls_pkg::WORD_W-1:0] suf_diff;
  logic [kls_pkg::WORD_W-1:0] suf_mask;
  logic [kls_pkg::POS_W-1:0]  pre_pos;
  logic [kls_pkg::POS_W-1:0]  suf_pos;
  logic [7:0]                 two_k1;
  logic [6:0]                 k2;
  logic [7:0]                 two_k2;
  logic [7:0]                 suf_part;
  logic [8:0]                 len_raw;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  assign two_k1 = {1'b0, cfg.prefix_length, 1'b0};
  assign k2     = ({1'b0, cfg.kmer_length} > {2'b00, cfg.prefix_length}) ?
                  7'(cfg.kmer_length - {1'b0, cfg.prefix_length}) : 7'd0;
  assign two_k2 = {k2, 1'b0};

  // A suffix of 32 or more nucleotides is compared over the whole word.
  assign suf_mask = (two_k2 < 8'd64) ? ~({kls_pkg::WORD_W{1'b1}} << two_k2[5:0])
                                     : {kls_pkg::WORD_W{1'b1}};

  assign pre_diff = in_data.first_prefix ^ in_data.second_prefix;
  assign suf_diff = (in_data.first_suffix ^ in_data.second_suffix) & suf_mask;
  assign pre_pos  = kls_pkg::top_bit_pos(pre_diff);
  assign suf_pos  = kls_pkg::top_bit_pos(suf_diff);

  always_comb begin
    suf_part = (two_k2 > {1'b0, suf_pos}) ? 8'((two_k2 - {1'b0, suf_pos}) >> 1) : 8'd0;
    priority if (pre_diff != '0) begin
      len_raw = (two_k1 > {1'b0, pre_pos}) ?
                9'((two_k1 - {1'b0, pre_pos}) >> 1) : 9'd0;
    end else if (suf_diff != '0) begin
      len_raw = {1'b0, suf_part} + {3'b000, cfg.prefix_length};
    end else begin
      len_raw = {2'b00, cfg.kmer_length};
    end
    q_len = (len_raw > {2'b00, kls_pkg::LEN_MAX}) ? kls_pkg::LEN_MAX
                                                  : len_raw[kls_pkg::LEN_W-1:0];
  end

endmodule

FILE: src/kls_queue.sv
// Short queue of prefix lengths between the front and back ends.
module kls_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [kls_pkg::LEN_W-1:0]    push_len,
  input  logic                         pop,
  output logic [kls_pkg::LEN_W-1:0]    head_len,
  output kls_pkg::kls_qstat_t          stat
);

  logic [kls_pkg::LEN_W-1:0]  mem_r [kls_pkg::QUEUE_DEPTH];
  logic [kls_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [kls_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [kls_pkg::QPTR_W:0]   count_r, count_nxt;

  assign stat.full  = (count_r == (kls_pkg::QPTR_W+1)'(kls_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_len   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_len;
    end
  end

endmodule

FILE: src/kls_back.sv
// Back end: updates the saturating totals and holds the result for the output channel.
module kls_back #(
  parameter int COUNT_WIDTH = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kls_pkg::kls_qstat_t          q_stat,
  input  logic [kls_pkg::LEN_W-1:0]    q_len,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output kls_pkg::kls_out_t            out_data
);

  logic [kls_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [kls_pkg::SQ_W-1:0]   sq_sum_r, sq_sum_nxt;
  logic [COUNT_WIDTH-1:0]     pairs_r, pairs_nxt;
  logic                       out_valid_r;
  kls_pkg::kls_out_t          out_data_r, out_data_nxt;

  logic [2*kls_pkg::LEN_W-1:0] len_sq;
  logic [kls_pkg::SUM_W:0]     sum_add;
  logic [kls_pkg::SQ_W:0]      sq_add;
  logic [47:0]                 pairs_ext;

  assign q_pop     = !q_stat.empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign len_sq  = q_len * q_len;
  assign sum_add = {1'b0, sum_r} + (kls_pkg::SUM_W+1)'(q_len);
  assign sq_add  = {1'b0, sq_sum_r} + (kls_pkg::SQ_W+1)'(len_sq);

  always_comb begin
    sum_nxt    = sum_r;
    sq_sum_nxt = sq_sum_r;
    pairs_nxt  = pairs_r;
    // A full pair counter freezes all three totals.
    if (q_pop && (pairs_r != '1)) begin
      sum_nxt    = sum_add[kls_pkg::SUM_W] ? '1 : sum_add[kls_pkg::SUM_W-1:0];
      sq_sum_nxt = sq_add[kls_pkg::SQ_W]   ? '1 : sq_add[kls_pkg::SQ_W-1:0];
      pairs_nxt  = pairs_r + 1'b1;
    end
    pairs_ext                     = 48'(pairs_nxt);
    out_data_nxt.lcp_length       = q_len;
    out_data_nxt.lcp_total        = sum_nxt;
    out_data_nxt.lcp_square_total = sq_sum_nxt;
    out_data_nxt.pair_count       = pairs_ext[kls_pkg::PAIR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      sq_sum_r    <= '0;
      pairs_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      sq_sum_r <= sq_sum_nxt;
      pairs_r  <= pairs_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: src/kmer_lcp_stats_core.sv
// Top level of the k-mer common prefix statistics block.
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+------------------------------
//   in      | in_valid, in_stall, in_data    | input     | one k-mer pair per transfer
//   out     | out_valid, out_stall, out_data | output    | length and totals per transfer
//   cfg     | cfg_wr_en, cfg_index, cfg_data | input     | one register write per cycle
//
// One pair per cycle sustained while the output does not stall; the prefix length search
// and the queue write share the cycle of the input transfer, and the totals update and
// output register load in the cycle that the entry is popped from the queue.
// Reset clears the totals, the queue and the output valid, and loads the register defaults.
// A stalled output fills the four-entry queue before the input channel stalls.
module kmer_lcp_stats_core #(
  parameter int COUNT_WIDTH = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kls_pkg::kls_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output kls_pkg::kls_out_t                 out_data,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [kls_pkg::CFG_DATA_W-1:0]    cfg_data
);

  kls_pkg::kls_cfg_t          cfg_r, cfg_nxt;
  kls_pkg::kls_qstat_t        q_stat;
  logic                       q_push;
  logic                       q_pop;
  logic [kls_pkg::LEN_W-1:0]  push_len;
  logic [kls_pkg::LEN_W-1:0]  head_len;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        kls_pkg::CFG_KMER_LENGTH:   cfg_nxt.kmer_length   = cfg_data;
        kls_pkg::CFG_PREFIX_LENGTH: cfg_nxt.prefix_length = cfg_data[kls_pkg::K1_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kmer_length   <= kls_pkg::KMER_LENGTH_RST;
      cfg_r.prefix_length <= kls_pkg::PREFIX_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kls_front u_front (
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_len    (push_len)
  );

  kls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_len (push_len),
    .pop      (q_pop),
    .head_len (head_len),
    .stat     (q_stat)
  );

  kls_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_len     (head_len),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The back end never takes from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // A transfer into the queue without a pop leaves it holding an entry.
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> !q_stat.empty)
    else $error("queue empty after push");

  // Taking from the queue always presents a result on the next cycle.
  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && (out_data.lcp_length == $past(head_len))))
    else $error("popped length not presented");

endmodule
